// ===== rtl/core/rv32i_instruction_execute_core_macros.svh =====
// ----------------------------------------------------------------------------
// RV32I execute core assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef RV32I_INSTRUCTION_EXECUTE_CORE_MACROS_SVH
`define RV32I_INSTRUCTION_EXECUTE_CORE_MACROS_SVH

// Same-cycle implication
`define RIE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RIE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rie_pkg.sv =====
// ----------------------------------------------------------------------------
// RV32I execute core package
// Opcodes, funct3 codes, payload and stage types, load data formatting.
// ----------------------------------------------------------------------------
package rie_pkg;

    // Data memory size in bytes; a power of two, 16 or more
    localparam int unsigned MEM_BYTES_DEF = 1024;
    localparam int unsigned STORE_ADDR_W  = 10;

    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_FENCE  = 7'b0001111;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;

    localparam logic [2:0] F3_SB = 3'd0;
    localparam logic [2:0] F3_SH = 3'd1;
    localparam logic [2:0] F3_SW = 3'd2;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    typedef struct packed {
        logic [31:0] instruction;
    } instr_t;

    typedef struct packed {
        logic [31:0]             next_pc;
        logic                    wb_enable;
        logic [4:0]              wb_reg;
        logic [31:0]             wb_value;
        logic                    store_enable;
        logic [STORE_ADDR_W-1:0] store_addr;
        logic                    illegal;
    } res_t;

    // Execute stage outcome
    typedef struct packed {
        logic [31:0] npc;
        logic        wr;
        logic [4:0]  rd;
        logic [31:0] val;
        logic        ld;
        logic        st;
        logic [2:0]  f3;
        logic [31:0] addr;
        logic [31:0] sdata;
        logic [3:0]  smask;
        logic        bad;
    } ex_t;

    // rdata is indexed by bank; lane is the bank of the first byte
    function automatic logic [31:0] load_value(input logic [3:0][7:0] rdata,
                                               input logic [1:0]      lane,
                                               input logic [2:0]      f3);
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [31:0] v;
        b0 = rdata[lane];
        b1 = rdata[2'(lane + 2'd1)];
        b2 = rdata[2'(lane + 2'd2)];
        b3 = rdata[2'(lane + 2'd3)];
        case (f3)
            F3_LB:   v = {{24{b0[7]}}, b0};
            F3_LH:   v = {{16{b1[7]}}, b1, b0};
            F3_LW:   v = {b3, b2, b1, b0};
            F3_LBU:  v = {24'd0, b0};
            F3_LHU:  v = {16'd0, b1, b0};
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/rie_stream_if.sv =====
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rie_stream_if #(parameter type data_t = logic);

    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/core/rie_regfile.sv =====
// ----------------------------------------------------------------------------
// RV32I register file
// 32 x 32 storage, two registered read ports with write-through, valid bits
// so that unwritten registers read zero after reset.
// ----------------------------------------------------------------------------
module rie_regfile
    import rie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rd_en,
    input  logic [4:0]  ra1,
    input  logic [4:0]  ra2,
    input  logic        we,
    input  logic [4:0]  wa,
    input  logic [31:0] wd,
    output logic [31:0] q1,
    output logic [31:0] q2
);

    logic [31:0] mem [32];
    logic [31:0] vld_reg;
    logic [31:0] mem1_reg;
    logic [31:0] mem2_reg;
    logic [31:0] wd_reg;
    logic        byp1_reg;
    logic        byp2_reg;
    logic        hit1_reg;
    logic        hit2_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            mem1_reg <= mem[ra1];
            mem2_reg <= mem[ra2];
            wd_reg   <= wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            byp1_reg <= 1'b0;
            byp2_reg <= 1'b0;
            hit1_reg <= 1'b0;
            hit2_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[wa] <= 1'b1;
            end
            if (rd_en)
            begin
                byp1_reg <= we && (wa == ra1);
                byp2_reg <= we && (wa == ra2);
                hit1_reg <= vld_reg[ra1];
                hit2_reg <= vld_reg[ra2];
            end
        end
    end

    assign q1 = byp1_reg ? wd_reg : (hit1_reg ? mem1_reg : '0);
    assign q2 = byp2_reg ? wd_reg : (hit2_reg ? mem2_reg : '0);

endmodule

// ===== rtl/core/rie_dmem.sv =====
// ----------------------------------------------------------------------------
// RV32I data memory
// Four byte banks, little-endian, addresses wrap at the memory size;
// one access per cycle, registered read data per bank.
// ----------------------------------------------------------------------------
module rie_dmem
    import rie_pkg::*;
#(
    parameter int unsigned MEM_AW = 10
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic              rd_en,
    input  logic [MEM_AW-1:0] addr,
    input  logic [31:0]       wdata,
    input  logic [3:0]        wmask,
    output logic [3:0][7:0]   rdata
);

    localparam int unsigned ROWS = 2 ** (MEM_AW - 2);

    for (genvar j = 0; j < 4; j++)
    begin : g_bank
        logic [1:0]        k;
        logic [MEM_AW-1:0] byte_addr;
        logic [7:0]        bank [ROWS];
        logic [7:0]        q_reg;

        // k: position of this bank's byte within the access
        assign k         = 2'(j) - addr[1:0];
        assign byte_addr = addr + MEM_AW'(k);

        always_ff @(posedge clk)
        begin
            if (wr_en && wmask[k])
            begin
                bank[byte_addr[MEM_AW-1:2]] <= wdata[{k, 3'b000} +: 8];
            end
            if (rd_en)
            begin
                q_reg <= bank[byte_addr[MEM_AW-1:2]];
            end
        end

        assign rdata[j] = q_reg;
    end

endmodule

// ===== rtl/core/rie_exec.sv =====
// ----------------------------------------------------------------------------
// RV32I execute logic
// Decode, ALU, branch compare, next pc and memory address for one
// instruction.
// ----------------------------------------------------------------------------
module rie_exec
    import rie_pkg::*;
(
    input  logic [31:0] ins,
    input  logic [31:0] pc,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output ex_t         ex
);

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [31:0] immi;
    logic [31:0] imms;
    logic [31:0] immb;
    logic [31:0] immj;
    logic [31:0] immu;
    logic [31:0] pc4;
    logic [31:0] pc_imm;
    logic [31:0] sum_a;
    logic [31:0] y;
    logic [4:0]  sh;
    logic [31:0] alu;
    logic        take;

    assign opc  = ins[6:0];
    assign rd   = ins[11:7];
    assign f3   = ins[14:12];
    assign immi = {{20{ins[31]}}, ins[31:20]};
    assign imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    assign immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    assign immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    assign immu = {ins[31:12], 12'd0};

    assign pc4    = pc + 32'd4;
    assign pc_imm = pc + ((opc == OPC_JAL) ? immj : ((opc == OPC_BRANCH) ? immb : immu));
    assign sum_a  = a + ((opc == OPC_STORE) ? imms : immi);

    assign y  = (opc == OPC_OP) ? b : immi;
    assign sh = y[4:0];

    always_comb
    begin
        case (f3)
            F3_ADD:  alu = ((opc == OPC_OP) && ins[30]) ? a - y : a + y;
            F3_SLL:  alu = a << sh;
            F3_SLT:  alu = {31'd0, $signed(a) < $signed(y)};
            F3_SLTU: alu = {31'd0, a < y};
            F3_XOR:  alu = a ^ y;
            F3_SR:   alu = ins[30] ? 32'($signed(a) >>> sh) : a >> sh;
            F3_OR:   alu = a | y;
            default: alu = a & y;
        endcase
    end

    always_comb
    begin
        case (f3)
            F3_BEQ:  take = (a == b);
            F3_BNE:  take = (a != b);
            F3_BLT:  take = ($signed(a) < $signed(b));
            F3_BGE:  take = ($signed(a) >= $signed(b));
            F3_BLTU: take = (a < b);
            F3_BGEU: take = (a >= b);
            default: take = 1'b0;
        endcase
    end

    always_comb
    begin
        ex       = '0;
        ex.npc   = pc4;
        ex.rd    = rd;
        ex.f3    = f3;
        ex.addr  = sum_a;
        ex.sdata = b;
        case (opc)
            OPC_LUI:
            begin
                ex.wr  = 1'b1;
                ex.val = immu;
            end
            OPC_AUIPC:
            begin
                ex.wr  = 1'b1;
                ex.val = pc_imm;
            end
            OPC_JAL:
            begin
                ex.wr  = 1'b1;
                ex.val = pc4;
                ex.npc = pc_imm;
            end
            OPC_JALR:
            begin
                ex.wr  = 1'b1;
                ex.val = pc4;
                ex.npc = {sum_a[31:1], 1'b0};
            end
            OPC_BRANCH:
            begin
                if (f3 inside {F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU})
                begin
                    if (take)
                    begin
                        ex.npc = pc_imm;
                    end
                end
                else
                begin
                    ex.bad = 1'b1;
                    ex.npc = pc;
                end
            end
            OPC_LOAD:
            begin
                ex.wr = 1'b1;
                if (f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU})
                begin
                    ex.ld = 1'b1;
                end
                else
                begin
                    ex.bad = 1'b1;
                end
            end
            OPC_STORE:
            begin
                case (f3)
                    F3_SB:
                    begin
                        ex.st    = 1'b1;
                        ex.smask = 4'b0001;
                    end
                    F3_SH:
                    begin
                        ex.st    = 1'b1;
                        ex.smask = 4'b0011;
                    end
                    F3_SW:
                    begin
                        ex.st    = 1'b1;
                        ex.smask = 4'b1111;
                    end
                    default: ex.bad = 1'b1;
                endcase
            end
            OPC_OPIMM, OPC_OP:
            begin
                ex.wr  = 1'b1;
                ex.val = alu;
            end
            OPC_FENCE, OPC_SYSTEM:
            begin
                ex.wr = 1'b0;
            end
            default:
            begin
                ex.bad = 1'b1;
                ex.npc = pc;
            end
        endcase
        // x0 is never written
        if (!ex.wr || (rd == 5'd0))
        begin
            ex.wr  = 1'b0;
            ex.rd  = '0;
            ex.val = '0;
            ex.ld  = 1'b0;
        end
    end

endmodule

// ===== rtl/core/rv32i_instruction_execute_core.sv =====
// ----------------------------------------------------------------------------
// RV32I instruction execute core
// Each instruction transfer passes through execute (register operands,
// ALU, branch, next pc, memory address) and then the memory stage, where
// the synchronous data memory read returns load data, before its result
// is loaded into the output register. A new instruction is taken every
// cycle while the output drains, and results are forwarded to the
// following instruction, so the sustained rate is one instruction per
// cycle; the longest path runs from the data memory read data through
// load formatting and forwarding into the next address adder.
// The register file resets to zero through per-register valid bits; data
// memory holds no reset state. MEM_BYTES must be a power of two, 16 or more.
// ----------------------------------------------------------------------------
`include "rv32i_instruction_execute_core_macros.svh"

module rv32i_instruction_execute_core
    import rie_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    rie_stream_if.sink    instr,
    rie_stream_if.source  result
);

    localparam int unsigned MEM_AW = $clog2(MEM_BYTES);

    typedef struct packed {
        logic [31:0]             npc;
        logic                    wr;
        logic [4:0]              rd;
        logic [31:0]             val;
        logic                    ld;
        logic [2:0]              f3;
        logic [1:0]              lane;
        logic                    st;
        logic [STORE_ADDR_W-1:0] saddr;
        logic                    bad;
    } mem_stage_t;

    logic            accept;
    logic            e_en;
    logic            m_en;
    logic            out_load;

    logic            e_vld_reg;
    instr_t          e_ins_reg;
    logic [31:0]     pc_reg;
    logic            m_vld_reg;
    mem_stage_t      m_reg;
    logic            o_vld_reg;
    res_t            o_reg;

    logic [31:0]     rf_q1;
    logic [31:0]     rf_q2;
    logic [31:0]     op_a;
    logic [31:0]     op_b;
    logic [31:0]     m_wb;
    ex_t             ex;
    logic            dm_wr;
    logic            dm_rd;
    logic [3:0][7:0] dm_rdata;

    assign out_load    = m_vld_reg && (!o_vld_reg || result.ready);
    assign m_en        = !m_vld_reg || out_load;
    assign e_en        = !e_vld_reg || m_en;
    assign instr.ready = e_en;
    assign accept      = instr.valid && e_en;

    assign m_wb = m_reg.ld ? load_value(dm_rdata, m_reg.lane, m_reg.f3) : m_reg.val;

    rie_regfile u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (accept),
        .ra1   (instr.data.instruction[19:15]),
        .ra2   (instr.data.instruction[24:20]),
        .we    (out_load && m_reg.wr),
        .wa    (m_reg.rd),
        .wd    (m_wb),
        .q1    (rf_q1),
        .q2    (rf_q2)
    );

    // Forward from the instruction still in the memory stage
    assign op_a = (m_vld_reg && m_reg.wr && (m_reg.rd == e_ins_reg.instruction[19:15]))
                  ? m_wb : rf_q1;
    assign op_b = (m_vld_reg && m_reg.wr && (m_reg.rd == e_ins_reg.instruction[24:20]))
                  ? m_wb : rf_q2;

    rie_exec u_exec (
        .ins (e_ins_reg.instruction),
        .pc  (pc_reg),
        .a   (op_a),
        .b   (op_b),
        .ex  (ex)
    );

    assign dm_wr = e_vld_reg && m_en && ex.st;
    assign dm_rd = e_vld_reg && m_en && ex.ld;

    rie_dmem #(
        .MEM_AW (MEM_AW)
    ) u_dmem (
        .clk   (clk),
        .wr_en (dm_wr),
        .rd_en (dm_rd),
        .addr  (ex.addr[MEM_AW-1:0]),
        .wdata (ex.sdata),
        .wmask (ex.smask),
        .rdata (dm_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
            pc_reg    <= '0;
        end
        else
        begin
            if (e_en)
            begin
                e_vld_reg <= instr.valid;
            end
            if (m_en)
            begin
                m_vld_reg <= e_vld_reg;
            end
            if (e_vld_reg && m_en)
            begin
                pc_reg <= ex.npc;
            end
            if (out_load)
            begin
                o_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                o_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_ins_reg <= instr.data;
        end
        if (e_vld_reg && m_en)
        begin
            m_reg.npc   <= ex.npc;
            m_reg.wr    <= ex.wr;
            m_reg.rd    <= ex.rd;
            m_reg.val   <= ex.val;
            m_reg.ld    <= ex.ld;
            m_reg.f3    <= ex.f3;
            m_reg.lane  <= ex.addr[1:0];
            m_reg.st    <= ex.st;
            m_reg.saddr <= ex.st ? STORE_ADDR_W'(ex.addr[MEM_AW-1:0]) : '0;
            m_reg.bad   <= ex.bad;
        end
        if (out_load)
        begin
            o_reg.next_pc      <= m_reg.npc;
            o_reg.wb_enable    <= m_reg.wr;
            o_reg.wb_reg       <= m_reg.rd;
            o_reg.wb_value     <= m_wb;
            o_reg.store_enable <= m_reg.st;
            o_reg.store_addr   <= m_reg.saddr;
            o_reg.illegal      <= m_reg.bad;
        end
    end

    assign result.valid = o_vld_reg;
    assign result.data  = o_reg;

    `RIE_ASSERT_NOW(a_wb_nonzero, clk, rst_n, o_vld_reg && o_reg.wb_enable, o_reg.wb_reg != 5'd0, "write-back to x0")
    `RIE_ASSERT_NOW(a_st_no_wb, clk, rst_n, o_vld_reg && o_reg.store_enable, !o_reg.wb_enable, "store with write-back")
    `RIE_ASSERT_NOW(a_dm_excl, clk, rst_n, dm_wr, !dm_rd, "data memory read and write together")
    `RIE_ASSERT_NEXT(a_m_hold, clk, rst_n, m_vld_reg && !m_en, m_vld_reg, "memory stage item lost")

endmodule
